/* rtl/pts_pkg.sv */
`timescale 1ns / 1ps

package pts_pkg;

    localparam int SLOTS  = 32;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int TIME_W = 16;
    localparam int SUM_W  = 22;
    localparam int PRIO_W = 2;

    typedef enum logic [1:0] {
        FUNC_LOAD,
        FUNC_TICK,
        FUNC_CLEAR,
        FUNC_NONE
    } func_t;

    typedef enum logic [1:0] {
        POL_FCFS,
        POL_SRT,
        POL_RR,
        POL_PRR
    } policy_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CLEAR,
        ST_OTHER,
        ST_TOP,
        ST_SEL,
        ST_FETCH,
        ST_UPDATE,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic              capture;
        logic              sel_init;
        logic              rd_en;
        logic              rd_pick;
        logic [SLOT_W-1:0] rd_addr;
        logic              eval_top;
        logic              eval_sel;
        logic              fetch;
        logic              update;
        logic              load;
        logic              clear;
        logic              res_clr;
    } cmd_t;

    typedef struct packed {
        policy_t policy;
    } stat_t;

endpackage

/* rtl/pts_ctrl.sv */
`timescale 1ns / 1ps

module pts_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [1:0]     func,
    input  pts_pkg::stat_t stat,
    output pts_pkg::cmd_t  cmd,
    output logic           busy,
    output logic           done
);

    pts_pkg::state_t state_reg, state_next;
    logic [pts_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic scan_last;

    assign scan_last = (cnt_reg == pts_pkg::CNT_W'(pts_pkg::SLOTS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pts_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            pts_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture  = 1'b1;
                    cmd.sel_init = 1'b1;
                    cnt_next     = '0;
                    unique case (pts_pkg::func_t'(func))
                        pts_pkg::FUNC_LOAD:  state_next = pts_pkg::ST_LOAD;
                        pts_pkg::FUNC_TICK:
                            state_next = (stat.policy == pts_pkg::POL_PRR) ?
                                         pts_pkg::ST_TOP : pts_pkg::ST_SEL;
                        pts_pkg::FUNC_CLEAR: state_next = pts_pkg::ST_CLEAR;
                        pts_pkg::FUNC_NONE:  state_next = pts_pkg::ST_OTHER;
                    endcase
                end
            end
            pts_pkg::ST_LOAD:
            begin
                cmd.load    = 1'b1;
                cmd.res_clr = 1'b1;
                state_next  = pts_pkg::ST_RESP;
            end
            pts_pkg::ST_CLEAR:
            begin
                cmd.clear   = 1'b1;
                cmd.res_clr = 1'b1;
                state_next  = pts_pkg::ST_RESP;
            end
            pts_pkg::ST_OTHER:
            begin
                cmd.res_clr = 1'b1;
                state_next  = pts_pkg::ST_RESP;
            end
            pts_pkg::ST_TOP:
            begin
                cmd.rd_en    = !scan_last;
                cmd.rd_addr  = cnt_reg[pts_pkg::SLOT_W-1:0];
                cmd.eval_top = (cnt_reg != '0);
                cnt_next     = cnt_reg + 1'b1;
                if (scan_last)
                begin
                    cmd.sel_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = pts_pkg::ST_SEL;
                end
            end
            pts_pkg::ST_SEL:
            begin
                cmd.rd_en    = !scan_last;
                cmd.rd_addr  = cnt_reg[pts_pkg::SLOT_W-1:0];
                cmd.eval_sel = (cnt_reg != '0);
                cnt_next     = cnt_reg + 1'b1;
                if (scan_last)
                begin
                    cnt_next   = '0;
                    state_next = pts_pkg::ST_FETCH;
                end
            end
            pts_pkg::ST_FETCH:
            begin
                cmd.fetch   = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_pick = 1'b1;
                state_next  = pts_pkg::ST_UPDATE;
            end
            pts_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = pts_pkg::ST_RESP;
            end
            pts_pkg::ST_RESP:
            begin
                done       = 1'b1;
                state_next = pts_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pts_pkg::ST_IDLE;
            end
        endcase
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= pts_pkg::CNT_W'(pts_pkg::SLOTS))
        else $error("scan counter out of range");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("item accepted but block not busy");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == pts_pkg::ST_UPDATE ||
                  $past(state_reg) == pts_pkg::ST_LOAD ||
                  $past(state_reg) == pts_pkg::ST_CLEAR ||
                  $past(state_reg) == pts_pkg::ST_OTHER))
        else $error("result strobe without finished work");

endmodule

/* rtl/pts_datapath.sv */
`timescale 1ns / 1ps

module pts_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pts_pkg::cmd_t               cmd,
    output pts_pkg::stat_t              stat,
    input  logic                        policy_we,
    input  logic [1:0]                  policy_wdata,
    input  logic [4:0]                  slot,
    input  logic [pts_pkg::TIME_W-1:0]  arrival,
    input  logic [15:0]                 run_length,
    input  logic [pts_pkg::PRIO_W-1:0]  prio,
    output logic                        ran,
    output logic [4:0]                  chosen,
    output logic                        completed,
    output logic [15:0]                 turnaround,
    output logic [15:0]                 time_now,
    output logic [pts_pkg::SUM_W-1:0]   total_turnaround,
    output logic                        all_done
);

    localparam logic [pts_pkg::SUM_W-1:0] SUM_MAX = '1;

    logic [pts_pkg::TIME_W-1:0] arr_mem  [pts_pkg::SLOTS];
    logic [15:0]                rem_mem  [pts_pkg::SLOTS];
    logic [pts_pkg::PRIO_W-1:0] prio_mem [pts_pkg::SLOTS];

    pts_pkg::policy_t           policy_reg;
    logic [pts_pkg::SLOTS-1:0]  use_reg;
    logic [pts_pkg::SLOTS-1:0]  fin_reg;
    logic [pts_pkg::TIME_W-1:0] time_reg;
    logic [pts_pkg::SUM_W-1:0]  sum_reg;
    logic [pts_pkg::CNT_W-1:0]  rr_reg;

    logic [4:0]                 slot_reg;
    logic [pts_pkg::TIME_W-1:0] arrival_reg;
    logic [15:0]                len_reg;
    logic [pts_pkg::PRIO_W-1:0] prio_reg;

    logic [pts_pkg::SLOT_W-1:0] rd_idx_reg;
    logic [pts_pkg::TIME_W-1:0] arr_rd_reg;
    logic [15:0]                rem_rd_reg;
    logic [pts_pkg::PRIO_W-1:0] prio_rd_reg;

    logic [pts_pkg::PRIO_W-1:0] top_reg;
    logic                       best_found_reg;
    logic [pts_pkg::SLOT_W-1:0] best_idx_reg;
    logic [15:0]                best_key_reg;
    logic [pts_pkg::CNT_W-1:0]  rdy_cnt_reg;
    logic [pts_pkg::SLOT_W-1:0] first_idx_reg;
    logic [pts_pkg::SLOT_W-1:0] t_idx_reg;

    logic                       found_reg;
    logic [pts_pkg::SLOT_W-1:0] pick_reg;

    logic                       ran_reg;
    logic [4:0]                 chosen_reg;
    logic                       completed_reg;
    logic [15:0]                turn_reg;

    logic                       load_ok;
    logic [pts_pkg::SLOT_W-1:0] load_idx;
    logic [pts_pkg::SLOT_W-1:0] rd_addr;
    logic                       ready;
    logic                       rr_mode;
    logic                       filt;
    logic [15:0]                key;
    logic [pts_pkg::CNT_W-1:0]  rr_t;
    logic                       t_hit;
    logic                       pick_found;
    logic [pts_pkg::SLOT_W-1:0] pick_idx;
    logic [15:0]                rem_new;
    logic                       fin_now;
    logic [pts_pkg::TIME_W-1:0] time_inc;
    logic [pts_pkg::TIME_W-1:0] turn_now;
    logic [pts_pkg::SUM_W:0]    sum_wide;

    assign load_ok  = ({1'b0, slot_reg} < 6'(pts_pkg::SLOTS));
    assign load_idx = slot_reg[pts_pkg::SLOT_W-1:0];
    assign rd_addr  = cmd.rd_pick ? pick_idx : cmd.rd_addr;
    assign ready    = use_reg[rd_idx_reg] && !fin_reg[rd_idx_reg] && (time_reg >= arr_rd_reg);
    assign rr_mode  = policy_reg[1];
    assign filt     = (policy_reg != pts_pkg::POL_PRR) || (prio_rd_reg == top_reg);
    assign key      = (policy_reg == pts_pkg::POL_FCFS) ? 16'(arr_rd_reg) : rem_rd_reg;
    assign rr_t     = rr_reg + 1'b1;
    assign t_hit    = (rdy_cnt_reg > rr_t);

    assign pick_found = rr_mode ? (rdy_cnt_reg != '0) : best_found_reg;
    assign pick_idx   = rr_mode ? (t_hit ? t_idx_reg : first_idx_reg) : best_idx_reg;

    assign rem_new  = rem_rd_reg - 16'(rem_rd_reg != 16'd0);
    assign fin_now  = (rem_new == 16'd0);
    assign time_inc = time_reg + 1'b1;
    assign turn_now = time_inc - arr_rd_reg;
    assign sum_wide = {1'b0, sum_reg} + (pts_pkg::SUM_W+1)'(turn_now);

    assign stat.policy = policy_reg;

    // table memories
    always_ff @(posedge clk)
    begin
        if (cmd.load && load_ok)
        begin
            arr_mem[load_idx]  <= arrival_reg;
            rem_mem[load_idx]  <= (len_reg == 16'd0) ? 16'd1 : len_reg;
            prio_mem[load_idx] <= prio_reg;
        end
        else if (cmd.update && found_reg)
        begin
            rem_mem[pick_reg] <= rem_new;
        end
        if (cmd.rd_en)
        begin
            arr_rd_reg  <= arr_mem[rd_addr];
            rem_rd_reg  <= rem_mem[rd_addr];
            prio_rd_reg <= prio_mem[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    // item capture, scan accumulators and result fields
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            slot_reg    <= slot;
            arrival_reg <= arrival;
            len_reg     <= run_length;
            prio_reg    <= prio;
        end
        if (cmd.eval_top && ready && (prio_rd_reg > top_reg))
        begin
            top_reg <= prio_rd_reg;
        end
        else if (cmd.capture)
        begin
            top_reg <= '0;
        end
        if (cmd.sel_init)
        begin
            best_found_reg <= 1'b0;
            rdy_cnt_reg    <= '0;
        end
        else if (cmd.eval_sel && ready)
        begin
            if (!best_found_reg || (key < best_key_reg))
            begin
                best_found_reg <= 1'b1;
                best_idx_reg   <= rd_idx_reg;
                best_key_reg   <= key;
            end
            if (filt)
            begin
                if (rdy_cnt_reg == '0)
                begin
                    first_idx_reg <= rd_idx_reg;
                end
                if (rdy_cnt_reg == rr_t)
                begin
                    t_idx_reg <= rd_idx_reg;
                end
                rdy_cnt_reg <= rdy_cnt_reg + 1'b1;
            end
        end
        if (cmd.fetch)
        begin
            found_reg <= pick_found;
            pick_reg  <= pick_idx;
        end
        if (cmd.res_clr)
        begin
            ran_reg       <= 1'b0;
            chosen_reg    <= '0;
            completed_reg <= 1'b0;
            turn_reg      <= '0;
        end
        else if (cmd.update)
        begin
            ran_reg       <= found_reg;
            chosen_reg    <= found_reg ? 5'(pick_reg) : 5'd0;
            completed_reg <= found_reg && fin_now;
            turn_reg      <= (found_reg && fin_now) ? 16'(turn_now) : 16'd0;
        end
    end

    // scheduler state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= pts_pkg::POL_FCFS;
            use_reg    <= '0;
            fin_reg    <= '0;
            time_reg   <= '0;
            sum_reg    <= '0;
            rr_reg     <= '1;
        end
        else
        begin
            if (policy_we)
            begin
                policy_reg <= pts_pkg::policy_t'(policy_wdata);
            end
            if (cmd.load && load_ok)
            begin
                use_reg[load_idx] <= 1'b1;
                fin_reg[load_idx] <= 1'b0;
            end
            if (cmd.clear)
            begin
                use_reg  <= '0;
                fin_reg  <= '0;
                time_reg <= '0;
                sum_reg  <= '0;
            end
            if (cmd.fetch && rr_mode)
            begin
                rr_reg <= t_hit ? rr_t : '0;
            end
            if (cmd.update)
            begin
                time_reg <= time_inc;
                if (found_reg && fin_now)
                begin
                    fin_reg[pick_reg] <= 1'b1;
                    sum_reg <= sum_wide[pts_pkg::SUM_W] ? SUM_MAX
                                                        : sum_wide[pts_pkg::SUM_W-1:0];
                end
            end
        end
    end

    assign ran              = ran_reg;
    assign chosen           = chosen_reg;
    assign completed        = completed_reg;
    assign turnaround       = turn_reg;
    assign time_now         = 16'(time_reg);
    assign total_turnaround = sum_reg;
    assign all_done         = ~|(use_reg & ~fin_reg);

    a_rr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rr_reg < pts_pkg::CNT_W'(pts_pkg::SLOTS)) || (rr_reg == '1))
        else $error("round robin position out of range");

    a_done_marks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && found_reg && fin_now |=> fin_reg[$past(pick_reg)])
        else $error("completed slot not marked finished");

endmodule

/* rtl/process_table_scheduler.sv */
`timescale 1ns / 1ps

// Process table scheduler. Start is taken when busy is low; each item gives one
// result, shown for one cycle while done is high, and the receiver cannot stall
// it, so it must take the result in that cycle. Load, clear and unused items
// go through their own state, then the response state. A tick reads the slot
// table through one memory port, one slot a cycle, in one pass under first come
// first served, shortest remaining and round robin, and in two under priority
// round robin: one for the top ready priority and a second to select. The policy
// register must be written with policy_we only while idle; the block does not enforce it.
module process_table_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        policy_we,
    input  logic [1:0]  policy_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [4:0]  slot,
    input  logic [15:0] arrival,
    input  logic [15:0] run_length,
    input  logic [1:0]  prio,
    output logic        done,
    output logic        ran,
    output logic [4:0]  chosen,
    output logic        completed,
    output logic [15:0] turnaround,
    output logic [15:0] time_now,
    output logic [21:0] total_turnaround,
    output logic        all_done
);

    pts_pkg::cmd_t  cmd;
    pts_pkg::stat_t stat;

    pts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    pts_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .policy_we        (policy_we),
        .policy_wdata     (policy_wdata),
        .slot             (slot),
        .arrival          (arrival),
        .run_length       (run_length),
        .prio             (prio),
        .ran              (ran),
        .chosen           (chosen),
        .completed        (completed),
        .turnaround       (turnaround),
        .time_now         (time_now),
        .total_turnaround (total_turnaround),
        .all_done         (all_done)
    );

endmodule

/* sim/process_table_scheduler_tb.sv */
`timescale 1ns / 1ps

module process_table_scheduler_tb;
    import pts_pkg::*;

    typedef struct {
        func_t       fn;
        logic [4:0]  sl;
        logic [15:0] arr;
        logic [15:0] len;
        logic [1:0]  pr;
    } sched_item_t;

    typedef struct {
        logic        ran;
        logic [4:0]  chosen;
        logic        completed;
        logic [15:0] turnaround;
        logic [15:0] time_now;
        logic [21:0] total;
        logic        all_done;
    } sched_result_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        policy_we = 0;
    logic [1:0]  policy_wdata = '0;
    logic        start = 0;
    logic        busy;
    logic [1:0]  func = '0;
    logic [4:0]  slot = '0;
    logic [15:0] arrival = '0;
    logic [15:0] run_length = '0;
    logic [1:0]  prio = '0;
    logic        done;
    logic        ran;
    logic [4:0]  chosen;
    logic        completed;
    logic [15:0] turnaround;
    logic [15:0] time_now;
    logic [21:0] total_turnaround;
    logic        all_done;

    process_table_scheduler dut (.*);

    always #1 clk = ~clk;

    // scheduler shadow state
    logic [15:0] arr_tab [SLOTS];
    logic [15:0] rem_tab [SLOTS];
    logic [1:0]  pri_tab [SLOTS];
    logic        fin_mark [SLOTS];
    logic        use_mark [SLOTS];
    logic [15:0] sim_time;
    int          rr_pos;
    logic [21:0] turn_sum;
    policy_t     cur_policy;

    sched_item_t   pending_items [$];
    sched_result_t expected_results [$];
    int  send_idle_pct = 25;
    bit  hold_send = 0;
    bit  last_accept = 0;
    int  errors = 0;
    int  sent = 0;
    int  checked = 0;
    int  ticks_run = 0;
    int  completions = 0;
    longint cycles = 0;

    function automatic bit slot_ready(int s);
        return use_mark[s] && !fin_mark[s] && sim_time >= arr_tab[s];
    endfunction

    function automatic int pick_slot();
        int best;
        int cnt;
        int lst [SLOTS];
        logic [1:0] top;
        best = -1;
        cnt = 0;
        top = 0;
        case (cur_policy)
            POL_FCFS:
                for (int s = 0; s < SLOTS; s++)
                    if (slot_ready(s) && (best < 0 || arr_tab[s] < arr_tab[best]))
                        best = s;
            POL_SRT:
                for (int s = 0; s < SLOTS; s++)
                    if (slot_ready(s) && (best < 0 || rem_tab[s] < rem_tab[best]))
                        best = s;
            default:
            begin
                if (cur_policy == POL_PRR)
                    for (int s = 0; s < SLOTS; s++)
                        if (slot_ready(s) && pri_tab[s] > top)
                            top = pri_tab[s];
                for (int s = 0; s < SLOTS; s++)
                    if (slot_ready(s) && (cur_policy != POL_PRR || pri_tab[s] == top))
                    begin
                        lst[cnt] = s;
                        cnt++;
                    end
                rr_pos++;
                if (cnt <= rr_pos)
                    rr_pos = 0;
                if (cnt > 0)
                    best = lst[rr_pos];
            end
        endcase
        return best;
    endfunction

    function automatic sched_result_t schedule_step(sched_item_t it);
        sched_result_t r;
        int p;
        logic [15:0] t;
        r = '{default: '0};
        case (it.fn)
            FUNC_LOAD:
            begin
                arr_tab[it.sl] = it.arr;
                rem_tab[it.sl] = (it.len == 0) ? 16'd1 : it.len;
                pri_tab[it.sl] = it.pr;
                fin_mark[it.sl] = 0;
                use_mark[it.sl] = 1;
            end
            FUNC_TICK:
            begin
                p = pick_slot();
                sim_time = sim_time + 16'd1;
                if (p >= 0)
                begin
                    r.ran = 1;
                    r.chosen = p[4:0];
                    if (rem_tab[p] > 0)
                        rem_tab[p]--;
                    if (rem_tab[p] == 0)
                    begin
                        fin_mark[p] = 1;
                        r.completed = 1;
                        t = sim_time - arr_tab[p];
                        r.turnaround = t;
                        if (32'(t) > 32'd4194303 - 32'(turn_sum))
                            turn_sum = 22'h3FFFFF;
                        else
                            turn_sum = turn_sum + 22'(t);
                    end
                end
            end
            FUNC_CLEAR:
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    fin_mark[s] = 0;
                    use_mark[s] = 0;
                end
                sim_time = 0;
                turn_sum = 0;
            end
            default:;
        endcase
        r.time_now = sim_time;
        r.total = turn_sum;
        r.all_done = 1;
        for (int s = 0; s < SLOTS; s++)
            if (use_mark[s] && !fin_mark[s])
                r.all_done = 0;
        return r;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n && !hold_send && pending_items.size() > 0 && !(start && !last_accept)
            && $urandom_range(99) >= send_idle_pct)
        begin
            sched_item_t it;
            it = pending_items.pop_front();
            start <= 1;
            func <= it.fn;
            slot <= it.sl;
            arrival <= it.arr;
            run_length <= it.len;
            prio <= it.pr;
        end
        else if (!(start && !last_accept))
            start <= 0;
    end

    // prediction at acceptance, monitor on done
    always @(posedge clk)
    begin
        cycles++;
        last_accept = start && !busy && rst_n;
        if (start && !busy && rst_n)
        begin
            sched_item_t it;
            sched_result_t r;
            it.fn = func_t'(func);
            it.sl = slot;
            it.arr = arrival;
            it.len = run_length;
            it.pr = prio;
            r = schedule_step(it);
            if (it.fn == FUNC_TICK && r.ran)
                ticks_run++;
            if (r.completed)
                completions++;
            expected_results.push_back(r);
            sent++;
        end
        if (done && rst_n)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no item pending");
                errors++;
            end
            else
            begin
                sched_result_t e;
                e = expected_results.pop_front();
                checked++;
                if (ran !== e.ran)
                begin
                    $error("ran exp %0d got %0d", e.ran, ran);
                    errors++;
                end
                if (chosen !== e.chosen)
                begin
                    $error("chosen exp %0d got %0d", e.chosen, chosen);
                    errors++;
                end
                if (completed !== e.completed)
                begin
                    $error("completed exp %0d got %0d", e.completed, completed);
                    errors++;
                end
                if (turnaround !== e.turnaround)
                begin
                    $error("turnaround exp %0d got %0d", e.turnaround, turnaround);
                    errors++;
                end
                if (time_now !== e.time_now)
                begin
                    $error("time_now exp %0d got %0d", e.time_now, time_now);
                    errors++;
                end
                if (total_turnaround !== e.total)
                begin
                    $error("total_turnaround exp %0d got %0d", e.total, total_turnaround);
                    errors++;
                end
                if (all_done !== e.all_done)
                begin
                    $error("all_done exp %0d got %0d", e.all_done, all_done);
                    errors++;
                end
            end
        end
        if (cycles > 400000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic add_item(func_t fn, int sl, int ar, int ln, int pr);
        sched_item_t it;
        it.fn = fn;
        it.sl = sl[4:0];
        it.arr = ar[15:0];
        it.len = ln[15:0];
        it.pr = pr[1:0];
        pending_items.push_back(it);
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic set_policy(policy_t p);
        @(negedge clk);
        policy_we <= 1;
        policy_wdata <= p;
        @(negedge clk);
        policy_we <= 0;
        cur_policy = p;
    endtask

    // a job mix: mostly ticks among mostly small loads, some noise
    task automatic random_burst(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 30)
                add_item(FUNC_LOAD, $urandom_range(31),
                         ($urandom_range(3) == 0) ? $urandom : sim_time + $urandom_range(12),
                         ($urandom_range(9) == 0) ? $urandom : $urandom_range(6),
                         $urandom_range(3));
            else if (r < 92)
                add_item(FUNC_TICK, $urandom, $urandom, $urandom, $urandom);
            else if (r < 96)
                add_item(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom);
            else
                add_item(FUNC_NONE, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            fin_mark[s] = 0;
            use_mark[s] = 0;
            arr_tab[s] = 0;
            rem_tab[s] = 0;
            pri_tab[s] = 0;
        end
        sim_time = 0;
        rr_pos = -1;
        turn_sum = 0;
        cur_policy = POL_FCFS;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: idle tick, field extremes, zero length, reload, unused code
        add_item(FUNC_TICK, 0, 0, 0, 0);
        add_item(FUNC_LOAD, 31, 0, 65535, 3);
        add_item(FUNC_LOAD, 0, 65535, 0, 0);
        add_item(FUNC_LOAD, 5, 1, 2, 1);
        add_item(FUNC_TICK, 0, 0, 0, 0);
        add_item(FUNC_TICK, 0, 0, 0, 0);
        add_item(FUNC_LOAD, 31, 2, 1, 2);
        add_item(FUNC_TICK, 0, 0, 0, 0);
        add_item(FUNC_TICK, 0, 0, 0, 0);
        add_item(FUNC_NONE, 31, 65535, 65535, 3);
        add_item(FUNC_TICK, 0, 0, 0, 0);
        add_item(FUNC_CLEAR, 0, 0, 0, 0);
        add_item(FUNC_TICK, 0, 0, 0, 0);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            set_policy(policy_t'(p));
            add_item(FUNC_LOAD, 1, 0, 3, 0);
            add_item(FUNC_LOAD, 2, 0, 1, 2);
            add_item(FUNC_LOAD, 3, 0, 2, 2);
            for (int i = 0; i < 5; i++)
                add_item(FUNC_TICK, 0, 0, 0, 0);
            add_item(FUNC_CLEAR, 0, 0, 0, 0);
            drain();
        end

        // random phases across policies and idle patterns
        for (int ph = 0; ph < 12; ph++)
        begin
            send_idle_pct = (ph < 4) ? 25 : (ph < 8) ? 50 : 0;
            set_policy(policy_t'(ph % 4));
            random_burst(50);
            if (ph == 5)
            begin
                while (pending_items.size() > 25)
                    @(posedge clk);
                hold_send = 1;
                while (start || expected_results.size() > 0)
                    @(posedge clk);
                hold_send = 0;
            end
            drain();
        end
        set_policy(POL_PRR);
        set_policy(POL_FCFS);
        drain();

        $display("covered %0d items, %0d ticks ran a slot, %0d completions, all policies",
                 sent, ticks_run, completions);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/pts_pkg.sv
rtl/pts_ctrl.sv
rtl/pts_datapath.sv
rtl/process_table_scheduler.sv
sim/process_table_scheduler_tb.sv
